// ----- design/imhpq_pkg.sv -----
// Package for the indexed min-heap priority queue.
// Holds command codes, status codes and the controller/datapath command and status structs.
package imhpq_pkg;

   localparam int KEY_W = 31;
   localparam int VTX_W = 8;
   localparam int VERTEX_IDS = 256;

   typedef enum logic [1:0] {
      MODE_INSERT  = 2'd0,
      MODE_EXTRACT = 2'd1,
      MODE_DECR    = 2'd2,
      MODE_QUERY   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_BAD   = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LATCH,
      OP_LOOKUP,
      OP_INS_WRITE,
      OP_EXT_READ_LAST,
      OP_EXT_WRITE_ROOT,
      OP_DECR_READ,
      OP_DECR_WRITE,
      OP_UP_READ,
      OP_UP_SWAP,
      OP_DOWN_READ,
      OP_DOWN_READ_R,
      OP_DOWN_PICK,
      OP_DOWN_SWAP,
      OP_RESULT
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       vertex_ok;
      logic       present;
      logic       full;
      logic       empty;
      logic       last_zero;
      logic       decr_take;
      logic       at_root;
      logic       up_swap;
      logic       down_swap;
   } stat_type;

endpackage

// ----- design/indexed_min_heap_priority_queue_top.sv -----
// A request is checked against the position map; query and rejected commands go straight to the
// result word, insert and decrease key sift the entry up and extract sifts the root down.
// Throughput: one item at a time, set by the heap walk; next request accepted the cycle after
// the result is loaded, while that word waits in the output register.
// Reset: synchronous, active high; clears the position map valid bits and fill count.
// Top level; instantiates imhpq_ctrl and imhpq_datapath, uses imhpq_pkg.
module indexed_min_heap_priority_queue_top #(
   parameter int MAX_VERTICES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // mode[1:0], vertex[9:2], key[40:10], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata   // out_vertex[7:0], out_key[38:8], status[40:39], is_member[41]
);
   import imhpq_pkg::*;

   localparam int SLOT_W = $clog2(MAX_VERTICES + 1);

   cmd_type    cmd;
   stat_type   stat;
   logic [7:0] ov;
   logic [30:0] okey;
   logic [1:0] st;
   logic       mem;

   imhpq_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .cmd(cmd), .stat(stat)
   );

   imhpq_datapath #(.MAX_VERTICES(MAX_VERTICES), .SLOT_W(SLOT_W)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .in_mode(req_tdata[1:0]), .in_vertex(req_tdata[9:2]), .in_key(req_tdata[40:10]),
      .out_vertex(ov), .out_key(okey), .out_status(st), .out_member(mem)
   );

   assign rsp_tdata = {6'd0, mem, st, okey, ov};

   logic unused_pad;
   assign unused_pad = ^req_tdata[47:41];
endmodule

// ----- design/imhpq_datapath.sv -----
// Datapath of the indexed min-heap: heap arrays, position map, slot pointer and result word.
// Depends on imhpq_pkg; driven by imhpq_ctrl through cmd_type and reports stat_type.
module imhpq_datapath #(
   parameter int MAX_VERTICES = 256,
   parameter int SLOT_W = 9
) (
   input  logic                       clock,
   input  logic                       reset,
   input  imhpq_pkg::cmd_type         cmd,
   output imhpq_pkg::stat_type        stat,
   input  logic [1:0]                 in_mode,
   input  logic [7:0]                 in_vertex,
   input  logic [30:0]                in_key,
   output logic [7:0]                 out_vertex,
   output logic [30:0]                out_key,
   output logic [1:0]                 out_status,
   output logic                       out_member
);
   import imhpq_pkg::*;

   localparam int IDX_W = (MAX_VERTICES > 2) ? $clog2(MAX_VERTICES) : 1;
   localparam logic [SLOT_W-1:0] NOT_PRESENT = SLOT_W'(MAX_VERTICES);

   logic [VTX_W-1:0]  hv_mem [MAX_VERTICES];
   logic [KEY_W-1:0]  hk_mem [MAX_VERTICES];
   logic [SLOT_W-1:0] pos_mem [VERTEX_IDS];
   logic [VERTEX_IDS-1:0] pos_valid_ff;

   logic [1:0]        mode_ff;
   logic [VTX_W-1:0]  vtx_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [SLOT_W-1:0] fill_ff;
   logic [SLOT_W-1:0] cur_ff;
   logic [SLOT_W-1:0] oth_ff;
   logic [SLOT_W-1:0] pos_rd_ff;
   logic              pos_hit_ff;
   logic [VTX_W-1:0]  av_ff, bv_ff, cv_ff;
   logic [KEY_W-1:0]  ak_ff, bk_ff, ck_ff;
   logic [VTX_W-1:0]  ov_ff;
   logic [KEY_W-1:0]  ok_ff;
   logic [1:0]        st_ff;
   logic              mem_ff;
   logic [VTX_W-1:0]  rv_ff;
   logic [KEY_W-1:0]  rk_ff;
   logic [1:0]        rs_ff;
   logic              rm_ff;

   logic [IDX_W-1:0]  cur_idx, par_idx, l_idx, r_idx, last_idx;
   logic [SLOT_W:0]   l_slot, r_slot;
   logic              vok, present;

   assign vok      = ({1'b0, vtx_ff} < (SLOT_W+1)'(MAX_VERTICES));
   assign present  = vok && pos_hit_ff;
   assign cur_idx  = cur_ff[IDX_W-1:0];
   assign par_idx  = IDX_W'((cur_ff - SLOT_W'(1)) >> 1);
   assign l_slot   = {cur_ff, 1'b1};
   assign r_slot   = {cur_ff, 1'b0} + (SLOT_W+1)'(2);
   assign l_idx    = l_slot[IDX_W-1:0];
   assign r_idx    = r_slot[IDX_W-1:0];
   assign last_idx = IDX_W'(fill_ff - SLOT_W'(1));

   always_comb begin
      stat.mode      = mode_ff;
      stat.vertex_ok = vok;
      stat.present   = present;
      stat.full      = (fill_ff == SLOT_W'(MAX_VERTICES));
      stat.empty     = (fill_ff == '0);
      stat.last_zero = (fill_ff == SLOT_W'(1));
      stat.decr_take = (pos_rd_ff < fill_ff) && (key_ff < ak_ff);
      stat.at_root   = (cur_ff == '0);
      stat.up_swap   = (ak_ff < bk_ff);
      stat.down_swap = (oth_ff != cur_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_valid_ff <= '0;
         fill_ff      <= '0;
      end else begin
         unique case (cmd.op)
            OP_LATCH: begin
               mode_ff <= in_mode;
               vtx_ff  <= in_vertex;
               key_ff  <= in_key;
               ov_ff   <= '0;
               ok_ff   <= '0;
               st_ff   <= ST_OK;
               mem_ff  <= 1'b0;
            end
            OP_LOOKUP: begin
               pos_hit_ff <= pos_valid_ff[vtx_ff];
               pos_rd_ff  <= pos_mem[vtx_ff];
               cur_ff     <= pos_mem[vtx_ff];
               av_ff      <= hv_mem[0];
               ak_ff      <= hk_mem[0];
               unique case (mode_ff)
                  MODE_INSERT: if (!vok || (pos_valid_ff[vtx_ff]) ||
                                  fill_ff == SLOT_W'(MAX_VERTICES)) st_ff <= ST_BAD;
                  MODE_EXTRACT: if (fill_ff == '0) st_ff <= ST_EMPTY;
                  MODE_DECR: if (!(vok && pos_valid_ff[vtx_ff])) st_ff <= ST_BAD;
                  MODE_QUERY: mem_ff <= vok && pos_valid_ff[vtx_ff];
                  default: ;
               endcase
            end
            OP_INS_WRITE: begin
               hv_mem[fill_ff[IDX_W-1:0]] <= vtx_ff;
               hk_mem[fill_ff[IDX_W-1:0]] <= key_ff;
               pos_mem[vtx_ff]            <= fill_ff;
               pos_valid_ff[vtx_ff]       <= 1'b1;
               cur_ff                     <= fill_ff;
               fill_ff                    <= fill_ff + SLOT_W'(1);
            end
            OP_EXT_READ_LAST: begin
               ov_ff <= av_ff;
               ok_ff <= ak_ff;
               bv_ff <= hv_mem[last_idx];
               bk_ff <= hk_mem[last_idx];
            end
            OP_EXT_WRITE_ROOT: begin
               if (fill_ff != SLOT_W'(1)) begin
                  hv_mem[0]      <= bv_ff;
                  hk_mem[0]      <= bk_ff;
                  pos_mem[bv_ff] <= '0;
               end
               pos_valid_ff[ov_ff] <= 1'b0;
               fill_ff <= fill_ff - SLOT_W'(1);
               cur_ff  <= '0;
            end
            OP_DECR_READ: begin
               ak_ff <= hk_mem[cur_idx];
            end
            OP_DECR_WRITE: begin
               hk_mem[cur_idx] <= key_ff;
            end
            OP_UP_READ: begin
               av_ff  <= hv_mem[cur_idx];
               ak_ff  <= hk_mem[cur_idx];
               bv_ff  <= hv_mem[par_idx];
               bk_ff  <= hk_mem[par_idx];
               oth_ff <= SLOT_W'(par_idx);
            end
            OP_UP_SWAP, OP_DOWN_SWAP: begin
               hv_mem[cur_idx] <= bv_ff;
               hk_mem[cur_idx] <= bk_ff;
               pos_mem[bv_ff]  <= cur_ff;
               hv_mem[oth_ff[IDX_W-1:0]] <= av_ff;
               hk_mem[oth_ff[IDX_W-1:0]] <= ak_ff;
               pos_mem[av_ff]  <= oth_ff;
               cur_ff          <= oth_ff;
            end
            OP_DOWN_READ: begin
               av_ff <= hv_mem[cur_idx];
               ak_ff <= hk_mem[cur_idx];
               bv_ff <= hv_mem[l_idx];
               bk_ff <= hk_mem[l_idx];
            end
            OP_DOWN_READ_R: begin
               cv_ff  <= hv_mem[r_idx];
               ck_ff  <= hk_mem[r_idx];
               oth_ff <= ((l_slot < {1'b0, fill_ff}) && (bk_ff < ak_ff)) ?
                         l_slot[SLOT_W-1:0] : cur_ff;
            end
            OP_DOWN_PICK: begin
               if ((r_slot < {1'b0, fill_ff}) &&
                   (ck_ff < ((oth_ff == cur_ff) ? ak_ff : bk_ff))) begin
                  oth_ff <= r_slot[SLOT_W-1:0];
                  bv_ff  <= cv_ff;
                  bk_ff  <= ck_ff;
               end
            end
            OP_RESULT: begin
               rv_ff <= ov_ff;
               rk_ff <= ok_ff;
               rs_ff <= st_ff;
               rm_ff <= mem_ff;
            end
            OP_NONE: ;
            default: ;
         endcase
      end
   end

   assign out_vertex = rv_ff;
   assign out_key    = rk_ff;
   assign out_status = rs_ff;
   assign out_member = rm_ff;

   logic unused_np;
   assign unused_np = ^NOT_PRESENT;
endmodule

// ----- design/imhpq_ctrl.sv -----
// Controller for the indexed min-heap: sequences lookup, write and sift steps per command.
// Depends on imhpq_pkg; commands imhpq_datapath and runs the request/response handshake.
module imhpq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output imhpq_pkg::cmd_type   cmd,
   input  imhpq_pkg::stat_type  stat
);
   import imhpq_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_LOOKUP, S_DECIDE, S_EXT_LAST, S_EXT_ROOT, S_DECR,
      S_UP_READ, S_UP_TEST, S_DN_READ, S_DN_READ_R, S_DN_PICK, S_DN_TEST, S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;
   logic      load_out;

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      load_out = 1'b0;
      unique case (state_ff)
         S_IDLE: if (req_tvalid && req_tready) begin
            cmd.op = OP_LATCH; state_in = S_LOOKUP;
         end
         S_LOOKUP: begin cmd.op = OP_LOOKUP; state_in = S_DECIDE; end
         S_DECIDE: begin
            state_in = S_OUT;
            unique case (stat.mode)
               MODE_INSERT: if (stat.vertex_ok && !stat.present && !stat.full) begin
                  cmd.op = OP_INS_WRITE; state_in = S_UP_READ;
               end
               MODE_EXTRACT: if (!stat.empty) state_in = S_EXT_LAST;
               MODE_DECR: if (stat.present) begin
                  cmd.op = OP_DECR_READ; state_in = S_DECR;
               end
               default: ;
            endcase
         end
         S_EXT_LAST: begin cmd.op = OP_EXT_READ_LAST; state_in = S_EXT_ROOT; end
         S_EXT_ROOT: begin cmd.op = OP_EXT_WRITE_ROOT; state_in = S_DN_READ; end
         S_DECR: if (stat.decr_take) begin
            cmd.op = OP_DECR_WRITE; state_in = S_UP_READ;
         end else state_in = S_OUT;
         S_UP_READ: if (stat.at_root) state_in = S_OUT;
            else begin cmd.op = OP_UP_READ; state_in = S_UP_TEST; end
         S_UP_TEST: if (stat.up_swap) begin
            cmd.op = OP_UP_SWAP; state_in = S_UP_READ;
         end else state_in = S_OUT;
         S_DN_READ: begin cmd.op = OP_DOWN_READ; state_in = S_DN_READ_R; end
         S_DN_READ_R: begin cmd.op = OP_DOWN_READ_R; state_in = S_DN_PICK; end
         S_DN_PICK: begin cmd.op = OP_DOWN_PICK; state_in = S_DN_TEST; end
         S_DN_TEST: if (stat.down_swap) begin
            cmd.op = OP_DOWN_SWAP; state_in = S_DN_READ;
         end else state_in = S_OUT;
         S_OUT: if (!valid_ff || rsp_tready) begin
            cmd.op = OP_RESULT; load_out = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      valid_in = valid_ff;
      if (valid_ff && rsp_tready) valid_in = 1'b0;
      if (load_out) valid_in = 1'b1;
   end

   // hold the word in the result register until taken; return to idle once loaded
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = valid_ff;
endmodule
